// File: src/equal_prob_sampler_no_replace_unit_macros.svh
// ---------------------------------------------------------------------------
// Sampler assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef EQUAL_PROB_SAMPLER_NO_REPLACE_UNIT_MACROS_SVH
`define EQUAL_PROB_SAMPLER_NO_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication
`define EPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define EPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/eps_pkg.sv
// ---------------------------------------------------------------------------
// Sampler package
// Word types, codes and defaults shared by the sampler modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package eps_pkg;

    // Defaults and fixed field widths
    localparam int unsigned POOL_DEPTH_DEF = 1024;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned CNT_W          = 11;
    localparam logic [CNT_W-1:0] POP_SIZE_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FILL   = 2'd2,
        OP_DRAW   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_DRAWN = 2'd0,
        STS_ACK   = 2'd1,
        STS_EMPTY = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_WB,
        S_FILL,
        S_RESP
    } state_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] item_value;
        logic [31:0]        random_fraction;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] drawn_value;
        status_t            status;
        logic [CNT_W-1:0]   remaining_count;
    } out_word_t;

endpackage

// File: src/eps_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module eps_ram #(
    parameter int unsigned WIDTH = eps_pkg::DATA_W,
    parameter int unsigned DEPTH = eps_pkg::POOL_DEPTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/equal_prob_sampler_no_replace_unit.sv
// ---------------------------------------------------------------------------
// Equal-probability sampler without replacement
// Pool of POOL_DEPTH 32-bit entries drawn by partial Fisher-Yates swaps.
// ---------------------------------------------------------------------------
// One result word per input word. Clear, append, a fill of size zero and a draw
// from an empty pool finish in the accept cycle. For a draw the pool RAM has one
// read port, so the last live entry is read in the accept cycle, the picked entry
// in S_PICK, and the last entry is written back into the picked slot in S_WB. An
// identity fill writes min(population_size, POOL_DEPTH) entries in S_FILL,
// one RAM write per entry. Input is taken whenever the sequencer is idle, also
// while the output register still holds a word; a finished result waits in a
// hold register if the output is stalled. The pool needs no clearing pass.
`timescale 1ns / 1ps

`include "equal_prob_sampler_no_replace_unit_macros.svh"

module equal_prob_sampler_no_replace_unit #(
    parameter int unsigned POOL_DEPTH = eps_pkg::POOL_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_we,
    input  logic [eps_pkg::CNT_W-1:0]     cfg_wdata,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  eps_pkg::in_word_t             s_word,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output eps_pkg::out_word_t            m_word
);

    localparam int unsigned AW = $clog2(POOL_DEPTH);
    localparam int unsigned LW = $clog2(POOL_DEPTH + 1);
    localparam int unsigned CW = (LW > eps_pkg::CNT_W) ? LW : eps_pkg::CNT_W;
    localparam int unsigned PW = LW + 32;
    localparam int unsigned DW = eps_pkg::DATA_W;

    eps_pkg::state_t             state_reg, state_next;
    logic [eps_pkg::CNT_W-1:0]   pop_reg;
    logic [LW-1:0]               live_reg, live_next;
    logic [PW-1:0]               prod_reg, prod_next;
    logic [DW-1:0]               last_reg, last_next;
    logic [AW-1:0]               pick_reg, pick_next;
    logic [LW-1:0]               fill_n_reg, fill_n_next;
    logic [AW-1:0]               fill_idx_reg, fill_idx_next;
    eps_pkg::out_word_t          res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    eps_pkg::out_word_t          m_word_reg, m_word_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [DW-1:0]               ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [DW-1:0]               ram_rdata;

    logic                        out_free;
    logic                        fin_valid;
    eps_pkg::out_word_t          fin_word;
    logic [CW-1:0]               pop_w;
    logic [LW-1:0]               fill_n_calc;
    logic [LW-1:0]               pick_raw;
    logic [LW-1:0]               pick_sel;
    logic [AW-1:0]               pick_addr;

    // Result word builder; count is shown modulo 2^11
    function automatic eps_pkg::out_word_t make_word(
        input logic [DW-1:0]    value,
        input eps_pkg::status_t sts,
        input logic [LW-1:0]    cnt
    );
        logic [CW-1:0]      cnt_w;
        eps_pkg::out_word_t w;
        cnt_w             = CW'(cnt);
        w.drawn_value     = value;
        w.status          = sts;
        w.remaining_count = cnt_w[eps_pkg::CNT_W-1:0];
        return w;
    endfunction

    // Pool memory
    eps_ram #(
        .WIDTH (DW),
        .DEPTH (POOL_DEPTH)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Fill length, saturated at pool depth
    assign pop_w       = CW'(pop_reg);
    assign fill_n_calc = (pop_w > CW'(POOL_DEPTH)) ? LW'(POOL_DEPTH) : LW'(pop_w);

    // Pick position: high word of live_count * r, kept below live_count
    assign pick_raw  = prod_reg[PW-1:32];
    assign pick_sel  = (pick_raw >= live_reg) ? (live_reg - LW'(1)) : pick_raw;
    assign pick_addr = AW'(pick_sel);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == eps_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_reg <= eps_pkg::POP_SIZE_RST;
        end else if (cfg_we) begin
            pop_reg <= cfg_wdata;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= eps_pkg::S_IDLE;
            live_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        last_reg     <= last_next;
        pick_reg     <= pick_next;
        fill_n_reg   <= fill_n_next;
        fill_idx_reg <= fill_idx_next;
        res_reg      <= res_next;
        m_word_reg   <= m_word_next;
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        live_next     = live_reg;
        prod_next     = prod_reg;
        last_next     = last_reg;
        pick_next     = pick_reg;
        fill_n_next   = fill_n_reg;
        fill_idx_next = fill_idx_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_word_next   = m_word_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = pick_addr;
        fin_valid     = 1'b0;
        fin_word      = make_word('0, eps_pkg::STS_ACK, live_reg);

        case (state_reg)
            eps_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (s_word.opcode)
                        eps_pkg::OP_CLEAR: begin
                            live_next = '0;
                            fin_valid = 1'b1;
                            fin_word  = make_word('0, eps_pkg::STS_ACK, '0);
                        end
                        eps_pkg::OP_APPEND: begin
                            fin_valid = 1'b1;
                            if (live_reg == LW'(POOL_DEPTH)) begin
                                fin_word = make_word('0, eps_pkg::STS_FULL, live_reg);
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(live_reg);
                                ram_wdata = s_word.item_value;
                                live_next = live_reg + LW'(1);
                                fin_word  = make_word('0, eps_pkg::STS_ACK,
                                                      live_reg + LW'(1));
                            end
                        end
                        eps_pkg::OP_FILL: begin
                            fill_n_next   = fill_n_calc;
                            fill_idx_next = '0;
                            if (fill_n_calc == '0) begin
                                live_next = '0;
                                fin_valid = 1'b1;
                                fin_word  = make_word('0, eps_pkg::STS_ACK, '0);
                            end else begin
                                state_next = eps_pkg::S_FILL;
                            end
                        end
                        eps_pkg::OP_DRAW: begin
                            if (live_reg == '0) begin
                                fin_valid = 1'b1;
                                fin_word  = make_word('0, eps_pkg::STS_EMPTY, '0);
                            end else begin
                                // read the last live entry, form the product
                                ram_raddr  = AW'(live_reg - LW'(1));
                                prod_next  = PW'(live_reg) * PW'(s_word.random_fraction);
                                state_next = eps_pkg::S_PICK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            eps_pkg::S_PICK: begin
                last_next  = ram_rdata;
                ram_raddr  = pick_addr;
                pick_next  = pick_addr;
                state_next = eps_pkg::S_WB;
            end
            eps_pkg::S_WB: begin
                // last entry moves into the vacated slot
                ram_we    = 1'b1;
                ram_waddr = pick_reg;
                ram_wdata = last_reg;
                live_next = live_reg - LW'(1);
                fin_valid = 1'b1;
                fin_word  = make_word(ram_rdata, eps_pkg::STS_DRAWN, live_reg - LW'(1));
            end
            eps_pkg::S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_idx_reg;
                ram_wdata = DW'(fill_idx_reg);
                if (LW'(fill_idx_reg) == fill_n_reg - LW'(1)) begin
                    live_next = fill_n_reg;
                    fin_valid = 1'b1;
                    fin_word  = make_word('0, eps_pkg::STS_ACK, fill_n_reg);
                end else begin
                    fill_idx_next = fill_idx_reg + AW'(1);
                end
            end
            eps_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_reg;
                    state_next   = eps_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = eps_pkg::S_IDLE;
            end
        endcase

        // Hand the finished word to the output, or park it
        if (fin_valid) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_word_next  = fin_word;
                state_next   = eps_pkg::S_IDLE;
            end else begin
                res_next   = fin_word;
                state_next = eps_pkg::S_RESP;
            end
        end
    end

    // Checks
    `EPS_ASSERT_NOW(a_live_bound, 1'b1, live_reg <= LW'(POOL_DEPTH), "live count above depth")
    `EPS_ASSERT_NOW(a_pick_live, state_reg == eps_pkg::S_PICK, live_reg != '0, "draw with empty pool")
    `EPS_ASSERT_NEXT(a_wb_dec, state_reg == eps_pkg::S_WB, live_reg == $past(live_reg) - LW'(1), "draw did not decrement")
    `EPS_ASSERT_NOW(a_we_state, ram_we, state_reg == eps_pkg::S_IDLE || state_reg == eps_pkg::S_FILL || state_reg == eps_pkg::S_WB, "pool write in wrong state")

endmodule

// File: bench/sampler_draw_checker.sv
// ---------------------------------------------------------------------------
// Sampler result checker
// Watches the configuration port and both word channels of the sampler. It
// keeps a shadow pool, live count and fill size, predicts the result word
// for every accepted input word, and compares each accepted result word
// field by field against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sampler_draw_checker #(
    parameter int unsigned POOL_DEPTH = eps_pkg::POOL_DEPTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [eps_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  eps_pkg::in_word_t         s_word,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  eps_pkg::out_word_t        m_word,
    output int                        mismatch_count,
    output int                        words_in_flight
);

    import eps_pkg::*;

    // Shadow copy of the pool and its bookkeeping
    logic signed [DATA_W-1:0] shadow_pool [POOL_DEPTH];
    int unsigned              shadow_live;
    logic [CNT_W-1:0]         fill_size;
    out_word_t                pending_results [$];

    // Apply one input word to the shadow state and return its result word
    function automatic out_word_t predict_result(input in_word_t w);
        out_word_t   res;
        logic [63:0] prod;
        int unsigned pick;
        int unsigned n;
        int unsigned idx;
        res        = '0;
        res.status = STS_ACK;
        case (w.opcode)
            OP_CLEAR: begin
                shadow_live = 0;
            end
            OP_APPEND: begin
                if (shadow_live >= POOL_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    shadow_pool[shadow_live] = w.item_value;
                    shadow_live++;
                end
            end
            OP_FILL: begin
                // identity fill, clipped to the pool depth
                n = (fill_size > POOL_DEPTH) ? POOL_DEPTH : fill_size;
                for (idx = 0; idx < n; idx++)
                    shadow_pool[idx] = DATA_W'(idx);
                shadow_live = n;
            end
            default: begin
                if (shadow_live == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    // position = floor(live * r / 2^32), always below live
                    prod            = 64'(shadow_live) * 64'(w.random_fraction);
                    pick            = prod[63:32];
                    res.drawn_value = shadow_pool[pick];
                    res.status      = STS_DRAWN;
                    shadow_live--;
                    shadow_pool[pick] = shadow_pool[shadow_live];
                end
            end
        endcase
        res.remaining_count = shadow_live[CNT_W-1:0];
        return res;
    endfunction

    task automatic log_mismatch(input string want_text);
        if (mismatch_count < 10)
            $display("[%0t] result word mismatch: got value %0d status %0d count %0d, expected %s",
                     $time, m_word.drawn_value, m_word.status, m_word.remaining_count,
                     want_text);
        mismatch_count++;
    endtask

    // Sample everything at the rising edge
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            shadow_live     = 0;
            fill_size       = POP_SIZE_RST;
            mismatch_count  = 0;
            pending_results.delete();
        end else begin
            if (cfg_we)
                fill_size = cfg_wdata;

            // results first: a word taken in this cycle cannot be answered yet
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    log_mismatch("no word");
                end else begin
                    want = pending_results.pop_front();
                    if (m_word.drawn_value !== want.drawn_value ||
                        m_word.status !== want.status ||
                        m_word.remaining_count !== want.remaining_count)
                        log_mismatch($sformatf("value %0d status %0d count %0d",
                                               want.drawn_value, want.status,
                                               want.remaining_count));
                end
            end

            if (s_valid && s_ready)
                pending_results.push_back(predict_result(s_word));
        end
        words_in_flight = pending_results.size();
    end

endmodule

// File: bench/equal_prob_sampler_no_replace_unit_tb.sv
// ---------------------------------------------------------------------------
// Sampler testbench
// Drives the sampler with a short directed sequence (empty draws, full
// appends, value and fraction extremes, fill sizes zero, one, depth and
// above depth) followed by random episodes of fills, appends and draws,
// noise and output back-pressure. A checker beside the block predicts and
// compares every result word; this module only makes stimulus and reports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module equal_prob_sampler_no_replace_unit_tb;

    import eps_pkg::*;

    localparam int unsigned POOL_DEPTH    = POOL_DEPTH_DEF;
    localparam int          ITEM_TARGET   = 1550;
    localparam int          LONG_HOLD     = 400;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          TAIL_CYCLES   = 20;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_word;
    logic             m_valid;
    logic             m_ready;
    out_word_t        m_word;
    int               mismatch_count;
    int               words_in_flight;

    // Stimulus bookkeeping
    int          items_sent;
    int unsigned pool_plan;
    int unsigned pop_plan;
    bit          src_burst;
    bit          sink_burst;
    bit          sink_hold_req;

    equal_prob_sampler_no_replace_unit #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    sampler_draw_checker #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_word          (s_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word          (m_word),
        .mismatch_count  (mismatch_count),
        .words_in_flight (words_in_flight)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_fraction();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll == 2) return 32'($urandom_range(0, 255));
        if (roll == 3) return ~32'($urandom_range(0, 255));
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll == 0) return 32'h8000_0000;
        if (roll == 1) return 32'h7FFF_FFFF;
        if (roll == 2) return '0;
        if (roll == 3) return '1;
        return $urandom();
    endfunction

    // Offer one word after a random gap and hold it until taken.
    // Called and returns at a falling edge.
    task automatic send_word(input opcode_t op, input logic [31:0] value,
                             input logic [31:0] frac);
        in_word_t w;
        int       gap;
        gap = src_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        w.opcode          = op;
        w.item_value      = value;
        w.random_fraction = frac;
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        // rough pool size, only used to steer the sequences
        case (op)
            OP_CLEAR:  pool_plan = 0;
            OP_APPEND: if (pool_plan < POOL_DEPTH) pool_plan++;
            OP_FILL:   pool_plan = (pop_plan > POOL_DEPTH) ? POOL_DEPTH : pop_plan;
            default:   if (pool_plan > 0) pool_plan--;
        endcase
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (words_in_flight != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register writes happen only with the block idle
    task automatic write_pop_size(input logic [CNT_W-1:0] size);
        wait_results_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        pop_plan   = size;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Draw the pool down with some appends mixed in, then poke the empty pool
    task automatic drain_pool(input int max_steps, input int append_pct);
        int steps;
        steps = 0;
        while (pool_plan > 0 && steps < max_steps) begin
            if ($urandom_range(0, 99) < append_pct)
                send_word(OP_APPEND, pick_value(), $urandom());
            else
                send_word(OP_DRAW, $urandom(), pick_fraction());
            steps++;
        end
        if (pool_plan == 0)
            repeat ($urandom_range(0, 2)) send_word(OP_DRAW, $urandom(), pick_fraction());
    endtask

    // Stall the output for a long stretch while words keep coming
    task automatic pressure_burst();
        sink_hold_req = 1'b1;
        repeat (16) begin
            if ($urandom_range(0, 1))
                send_word(OP_APPEND, pick_value(), $urandom());
            else
                send_word(OP_DRAW, $urandom(), pick_fraction());
        end
        wait_results_done();
    endtask

    // Result side: random stalls, bursts, and the long hold-off on request
    initial begin : result_sink
        int stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (sink_burst || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall = pick_gap();
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int               roll;
        logic [CNT_W-1:0] size;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_word        = '0;
        items_sent    = 0;
        pool_plan     = 0;
        pop_plan      = POP_SIZE_RST;
        src_burst     = 1'b0;
        sink_burst    = 1'b0;
        sink_hold_req = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // draw from the empty pool straight out of reset
        send_word(OP_DRAW, $urandom(), '1);
        send_word(OP_CLEAR, '1, '1);
        // value extremes, then first, last and middle positions
        send_word(OP_APPEND, 32'h8000_0000, '0);
        send_word(OP_APPEND, 32'h7FFF_FFFF, '1);
        send_word(OP_APPEND, '0, $urandom());
        send_word(OP_APPEND, '1, $urandom());
        send_word(OP_DRAW, '0, '0);
        send_word(OP_DRAW, '1, '1);
        send_word(OP_DRAW, $urandom(), 32'h8000_0000);
        send_word(OP_DRAW, $urandom(), $urandom());
        // reset fill size fills the whole pool; append to a full pool
        send_word(OP_FILL, $urandom(), $urandom());
        send_word(OP_APPEND, pick_value(), $urandom());
        send_word(OP_DRAW, $urandom(), '1);
        send_word(OP_DRAW, $urandom(), '0);
        send_word(OP_APPEND, 32'h7FFF_FFFF, $urandom());
        send_word(OP_APPEND, 32'h8000_0000, $urandom());
        send_word(OP_CLEAR, $urandom(), $urandom());
        // fill size zero leaves the pool empty
        write_pop_size('0);
        send_word(OP_FILL, $urandom(), $urandom());
        send_word(OP_DRAW, $urandom(), $urandom());
        // fill size above depth saturates
        write_pop_size('1);
        send_word(OP_FILL, $urandom(), $urandom());
        send_word(OP_APPEND, pick_value(), $urandom());
        send_word(OP_CLEAR, $urandom(), $urandom());
        // single-entry fill drawn to empty
        write_pop_size(11'd1);
        send_word(OP_FILL, $urandom(), $urandom());
        send_word(OP_DRAW, $urandom(), '1);
        send_word(OP_DRAW, $urandom(), '1);

        pressure_burst();

        // random episodes
        while (items_sent < ITEM_TARGET) begin
            src_burst  = ($urandom_range(0, 4) == 0);
            sink_burst = ($urandom_range(0, 4) == 0);
            roll       = $urandom_range(0, 19);
            if (roll == 0) begin
                pressure_burst();
            end else if (roll == 1) begin
                // full pool: appends bounce, draws make room
                write_pop_size($urandom_range(0, 1) ? 11'd1024 : '1);
                send_word(OP_FILL, $urandom(), $urandom());
                repeat (2) send_word(OP_APPEND, pick_value(), $urandom());
                repeat (8) send_word(OP_DRAW, $urandom(), pick_fraction());
                repeat (10) send_word(OP_APPEND, pick_value(), $urandom());
                send_word(OP_CLEAR, $urandom(), $urandom());
            end else if (roll < 4) begin
                // noise: any opcode, any fields
                repeat ($urandom_range(5, 15))
                    send_word(opcode_t'($urandom_range(0, 3)), pick_value(),
                              pick_fraction());
            end else if (roll < 12) begin
                // identity fill, mostly small
                roll = $urandom_range(0, 99);
                if (roll < 75)      size = CNT_W'($urandom_range(1, 24));
                else if (roll < 83) size = CNT_W'($urandom_range(25, 200));
                else if (roll < 90) size = '0;
                else if (roll < 95) size = 11'd1024;
                else                size = CNT_W'($urandom_range(0, 2047));
                write_pop_size(size);
                send_word(OP_FILL, pick_value(), pick_fraction());
                drain_pool(60, 20);
            end else begin
                // appended pool
                send_word(OP_CLEAR, pick_value(), pick_fraction());
                repeat ($urandom_range(1, 32)) send_word(OP_APPEND, pick_value(), $urandom());
                drain_pool(80, 30);
            end
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/eps_pkg.sv
src/eps_ram.sv
src/equal_prob_sampler_no_replace_unit.sv
bench/sampler_draw_checker.sv
bench/equal_prob_sampler_no_replace_unit_tb.sv
